// File: hdl/hds_pkg.sv
// Shared constants, types and helpers of the heat diffusion stencil core.
package hds_pkg;

  localparam int MAX_GRID = 512;
  localparam int CoordW   = $clog2(MAX_GRID);
  localparam int GridW    = CoordW + 1;
  localparam int BoundW   = CoordW + 2;
  localparam int ValW     = 16;
  localparam int SumW     = ValW + 2;
  localparam int HeatW    = 7;
  localparam int EnW      = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;
  localparam int LineW    = 2 * ValW;
  localparam int QDEPTH   = 4;
  localparam int QPtrW    = $clog2(QDEPTH);
  localparam int QCntW    = $clog2(QDEPTH + 1);

  localparam logic [ValW-1:0] HOT_VALUE = ValW'(32768);
  localparam int              MIN_GRID  = 3;

  localparam logic [CfgDataW-1:0] GRID_SIZE_RST = CfgDataW'(400);
  localparam logic [HeatW-1:0]    HEAT_SIZE_RST = HeatW'(30);
  localparam logic [CoordW-1:0]   HEAT_A_RST    = CoordW'(100);
  localparam logic [CoordW-1:0]   HEAT_B_RST    = CoordW'(300);
  localparam logic [EnW-1:0]      HEAT_EN_RST   = EnW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_SIZE  = 3'd0,
    REG_HEAT_SIZE  = 3'd1,
    REG_HEAT_A_ROW = 3'd2,
    REG_HEAT_A_COL = 3'd3,
    REG_HEAT_B_ROW = 3'd4,
    REG_HEAT_B_COL = 3'd5,
    REG_HEAT_EN    = 3'd6
  } hds_reg_e;

  typedef struct packed {
    logic [ValW-1:0]   below;
    logic [ValW-1:0]   up;
    logic [ValW-1:0]   left;
    logic [ValW-1:0]   right;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              edge_cell;
    logic              two;
    logic              last_col;
  } hds_work_t;

  typedef struct packed {
    logic [EnW-1:0]           en;
    logic signed [BoundW-1:0] a_row_lo;
    logic signed [BoundW-1:0] a_row_hi;
    logic signed [BoundW-1:0] a_col_lo;
    logic signed [BoundW-1:0] a_col_hi;
    logic signed [BoundW-1:0] b_row_lo;
    logic signed [BoundW-1:0] b_row_hi;
    logic signed [BoundW-1:0] b_col_lo;
    logic signed [BoundW-1:0] b_col_hi;
  } hds_heat_t;

  function automatic logic in_span(input logic [CoordW-1:0] pos,
                                   input logic signed [BoundW-1:0] lo,
                                   input logic signed [BoundW-1:0] hi);
    logic signed [BoundW-1:0] p;
    p = signed'({2'b00, pos});
    return (p >= lo) && (p < hi);
  endfunction

endpackage

// File: hdl/hds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hds_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/hds_front.sv
// Front end: cell intake, position tracking, line buffer access and work classification.
module hds_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [hds_pkg::ValW-1:0]      cell_value_i,
  input  logic [hds_pkg::GridW-1:0]     grid_i,
  input  logic                          restart_i,
  input  logic [hds_pkg::QCntW-1:0]     q_count_i,
  output logic                          q_push_o,
  output hds_pkg::hds_work_t            q_data_o
);

  logic [hds_pkg::CoordW-1:0] cur_row_q, cur_row_d;
  logic [hds_pkg::CoordW-1:0] cur_col_q, cur_col_d;
  logic [hds_pkg::CoordW-1:0] gm1, nxt_col;
  logic [hds_pkg::ValW-1:0]   prev_cell_q;
  logic [hds_pkg::ValW-1:0]   mid, up;
  logic [hds_pkg::LineW-1:0]  line_rd;
  logic                       accept, last_col, last_row;
  logic                       s1_vld_q;
  hds_pkg::hds_work_t         s1_q;
  logic [hds_pkg::QCntW:0]    occ;

  assign occ    = {1'b0, q_count_i} + (hds_pkg::QCntW + 1)'(s1_vld_q);
  assign full   = occ >= (hds_pkg::QCntW + 1)'(hds_pkg::QDEPTH);
  assign accept = push && !full;

  assign gm1      = hds_pkg::CoordW'(grid_i - hds_pkg::GridW'(1));
  assign last_col = cur_col_q == gm1;
  assign last_row = cur_row_q == gm1;
  assign nxt_col  = last_col ? '0 : cur_col_q + hds_pkg::CoordW'(1);
  assign mid      = line_rd[hds_pkg::ValW-1:0];
  assign up       = line_rd[hds_pkg::LineW-1:hds_pkg::ValW];

  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    if (restart_i) begin
      cur_row_d = '0;
      cur_col_d = '0;
    end else if (accept) begin
      cur_col_d = nxt_col;
      if (last_col) begin
        cur_row_d = last_row ? '0 : cur_row_q + hds_pkg::CoordW'(1);
      end
    end
  end

  hds_ram #(
    .Width (hds_pkg::LineW),
    .Depth (hds_pkg::MAX_GRID)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (cur_col_q),
    .wdata_i ({mid, cell_value_i}),
    .re_i    (accept),
    .raddr_i (nxt_col),
    .rdata_o (line_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cur_col_q <= '0;
      s1_vld_q  <= 1'b0;
    end else begin
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      s1_vld_q  <= accept && (cur_row_q != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_cell_q    <= mid;
      s1_q.below     <= cell_value_i;
      s1_q.up        <= up;
      s1_q.left      <= prev_cell_q;
      s1_q.right     <= '0;
      s1_q.row       <= cur_row_q - hds_pkg::CoordW'(1);
      s1_q.col       <= cur_col_q;
      s1_q.edge_cell <= (cur_row_q == hds_pkg::CoordW'(1)) || (cur_col_q == '0) || last_col;
      s1_q.two       <= last_row;
      s1_q.last_col  <= last_col;
    end
  end

  always_comb begin
    q_data_o       = s1_q;
    q_data_o.right = line_rd[hds_pkg::ValW-1:0];
  end
  assign q_push_o = s1_vld_q;

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> q_count_i < hds_pkg::QCntW'(hds_pkg::QDEPTH))
    else $error("work word pushed into a full queue");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_col && !restart_i |=> cur_col_q == '0)
    else $error("column did not wrap at end of row");

endmodule

// File: hdl/hds_queue.sv
// Short work queue between the front end and the back end.
module hds_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  hds_pkg::hds_work_t        data_i,
  input  logic                      pop_i,
  output logic                      head_vld_o,
  output hds_pkg::hds_work_t        head_o,
  output logic [hds_pkg::QCntW-1:0] count_o
);

  hds_pkg::hds_work_t         mem_q [hds_pkg::QDEPTH];
  logic [hds_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [hds_pkg::QCntW-1:0]  count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + hds_pkg::QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - hds_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + hds_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + hds_pkg::QPtrW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign head_vld_o = count_q != '0;
  assign head_o     = mem_q[rd_ptr_q];
  assign count_o    = count_q;

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty work queue");

endmodule

// File: hdl/hds_back.sv
// Back end: stencil average, heater and edge override, result word register.
module hds_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_vld_i,
  input  hds_pkg::hds_work_t         head_i,
  output logic                       q_pop_o,
  input  hds_pkg::hds_heat_t         heat_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [hds_pkg::ValW-1:0]   new_value_o,
  output logic [hds_pkg::CoordW-1:0] out_row_o,
  output logic [hds_pkg::CoordW-1:0] out_col_o,
  output logic                       frame_last_o,
  output logic                       run_last_o
);

  logic                       phase_q;
  logic                       out_vld_q;
  logic [hds_pkg::ValW-1:0]   new_value_q;
  logic [hds_pkg::CoordW-1:0] out_row_q, out_col_q;
  logic                       frame_last_q, run_last_q;
  logic [hds_pkg::CoordW-1:0] row_sel;
  logic [hds_pkg::SumW-1:0]   sum;
  logic [hds_pkg::ValW-1:0]   val;
  logic                       heat_a, heat_b, heated, last_word, load;

  assign row_sel = phase_q ? head_i.row + hds_pkg::CoordW'(1) : head_i.row;
  assign sum = hds_pkg::SumW'(head_i.up) + hds_pkg::SumW'(head_i.below)
             + hds_pkg::SumW'(head_i.left) + hds_pkg::SumW'(head_i.right);

  assign heat_a = heat_i.en[0]
               && hds_pkg::in_span(row_sel, heat_i.a_row_lo, heat_i.a_row_hi)
               && hds_pkg::in_span(head_i.col, heat_i.a_col_lo, heat_i.a_col_hi);
  assign heat_b = heat_i.en[1]
               && hds_pkg::in_span(row_sel, heat_i.b_row_lo, heat_i.b_row_hi)
               && hds_pkg::in_span(head_i.col, heat_i.b_col_lo, heat_i.b_col_hi);
  assign heated = heat_a || heat_b;

  always_comb begin
    priority if (heated) begin
      val = hds_pkg::HOT_VALUE;
    end else if (phase_q || head_i.edge_cell) begin
      val = '0;
    end else begin
      val = sum[hds_pkg::SumW-1:2];
    end
  end

  assign last_word = phase_q || !head_i.two;
  assign load      = head_vld_i && (!out_vld_q || pop);
  assign q_pop_o   = load && last_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (load) begin
        phase_q <= !last_word;
      end
      out_vld_q <= load || (out_vld_q && !pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      new_value_q  <= val;
      out_row_q    <= row_sel;
      out_col_q    <= head_i.col;
      frame_last_q <= phase_q && head_i.last_col;
      run_last_q   <= last_word;
    end
  end

  assign empty        = !out_vld_q;
  assign new_value_o  = new_value_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = frame_last_q;
  assign run_last_o   = run_last_q;

  a_phase_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> head_vld_i && head_i.two)
    else $error("second word pending without a last-row work word");

  a_frame_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && frame_last_q |-> run_last_q)
    else $error("frame end word not flagged as last of its run");

endmodule

// File: hdl/heat_diffusion_stencil_core.sv
// Top level of the five-point heat stencil core: configuration registers and block wiring.
// Cells enter one per clock in row-major order while full is low, and results leave one per
// clock while pop is high: a cell of row r gives the word for row r-1, the last row also
// gives its own words, so each cell of the last row gives two result words and row 0 gives
// no word. A word passes through the front-end stage register, the work queue and the result
// word register. The single line buffer RAM holds MAX_GRID entries of two packed rows, with
// one read and one write per cell. The line buffer is not cleared after reset; its old
// contents reach only edge cells, which are forced, so the block takes cells from the first
// clock after reset. A write to grid_size restarts the frame at cell (0, 0).
module heat_diffusion_stencil_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [hds_pkg::ValW-1:0]     cell_value_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [hds_pkg::ValW-1:0]     new_value_o,
  output logic [hds_pkg::CoordW-1:0]   out_row_o,
  output logic [hds_pkg::CoordW-1:0]   out_col_o,
  output logic                         frame_last_o,
  output logic                         run_last_o,
  input  logic                         cfg_we_i,
  input  logic [hds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hds_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic [hds_pkg::CfgDataW-1:0] grid_size_q;
  logic [hds_pkg::HeatW-1:0]    heat_size_q;
  logic [hds_pkg::CoordW-1:0]   heat_a_row_q, heat_a_col_q, heat_b_row_q, heat_b_col_q;
  logic [hds_pkg::EnW-1:0]      heat_en_q;
  logic [hds_pkg::GridW-1:0]    grid;
  logic signed [hds_pkg::BoundW-1:0] half, span;
  logic                         restart;
  hds_pkg::hds_heat_t           heat;
  hds_pkg::hds_work_t           q_data, q_head;
  logic                         q_push, q_pop, q_head_vld;
  logic [hds_pkg::QCntW-1:0]    q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q  <= hds_pkg::GRID_SIZE_RST;
      heat_size_q  <= hds_pkg::HEAT_SIZE_RST;
      heat_a_row_q <= hds_pkg::HEAT_A_RST;
      heat_a_col_q <= hds_pkg::HEAT_A_RST;
      heat_b_row_q <= hds_pkg::HEAT_B_RST;
      heat_b_col_q <= hds_pkg::HEAT_B_RST;
      heat_en_q    <= hds_pkg::HEAT_EN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hds_pkg::REG_GRID_SIZE:  grid_size_q  <= cfg_wdata_i;
        hds_pkg::REG_HEAT_SIZE:  heat_size_q  <= cfg_wdata_i[hds_pkg::HeatW-1:0];
        hds_pkg::REG_HEAT_A_ROW: heat_a_row_q <= cfg_wdata_i[hds_pkg::CoordW-1:0];
        hds_pkg::REG_HEAT_A_COL: heat_a_col_q <= cfg_wdata_i[hds_pkg::CoordW-1:0];
        hds_pkg::REG_HEAT_B_ROW: heat_b_row_q <= cfg_wdata_i[hds_pkg::CoordW-1:0];
        hds_pkg::REG_HEAT_B_COL: heat_b_col_q <= cfg_wdata_i[hds_pkg::CoordW-1:0];
        hds_pkg::REG_HEAT_EN:    heat_en_q    <= cfg_wdata_i[hds_pkg::EnW-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && (cfg_idx_i == hds_pkg::REG_GRID_SIZE);

  always_comb begin
    priority if (int'(grid_size_q) > hds_pkg::MAX_GRID) begin
      grid = hds_pkg::GridW'(hds_pkg::MAX_GRID);
    end else if (int'(grid_size_q) < hds_pkg::MIN_GRID) begin
      grid = hds_pkg::GridW'(hds_pkg::MIN_GRID);
    end else begin
      grid = hds_pkg::GridW'(grid_size_q);
    end
  end

  assign half = signed'(hds_pkg::BoundW'(heat_size_q >> 1));
  assign span = signed'(hds_pkg::BoundW'(heat_size_q));

  always_comb begin
    heat.en       = heat_en_q;
    heat.a_row_lo = signed'({2'b00, heat_a_row_q}) - half;
    heat.a_col_lo = signed'({2'b00, heat_a_col_q}) - half;
    heat.b_row_lo = signed'({2'b00, heat_b_row_q}) - half;
    heat.b_col_lo = signed'({2'b00, heat_b_col_q}) - half;
    heat.a_row_hi = heat.a_row_lo + span;
    heat.a_col_hi = heat.a_col_lo + span;
    heat.b_row_hi = heat.b_row_lo + span;
    heat.b_col_hi = heat.b_col_lo + span;
  end

  hds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .cell_value_i (cell_value_i),
    .grid_i       (grid),
    .restart_i    (restart),
    .q_count_i    (q_count),
    .q_push_o     (q_push),
    .q_data_o     (q_data)
  );

  hds_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .data_i     (q_data),
    .pop_i      (q_pop),
    .head_vld_o (q_head_vld),
    .head_o     (q_head),
    .count_o    (q_count)
  );

  hds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_vld_i   (q_head_vld),
    .head_i       (q_head),
    .q_pop_o      (q_pop),
    .heat_i       (heat),
    .empty        (empty),
    .pop          (pop),
    .new_value_o  (new_value_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_last_o (frame_last_o),
    .run_last_o   (run_last_o)
  );

  a_full_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> q_count < hds_pkg::QCntW'(hds_pkg::QDEPTH))
    else $error("queue full while intake open");

endmodule
